### hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hdl/ffc_pkg.sv
// Package with widths, key codes and shared types of the calculator.
package ffc_pkg;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned FRAC_BITS  = 32;
  localparam int unsigned WIDE_BITS  = 2 * VALUE_BITS;
  localparam int unsigned CNT_BITS   = $clog2(WIDE_BITS + 1);

  typedef enum logic [3:0] {
    KEY_DIGIT  = 4'd0,
    KEY_POINT  = 4'd1,
    KEY_NEGATE = 4'd2,
    KEY_ADD    = 4'd3,
    KEY_SUB    = 4'd4,
    KEY_MUL    = 4'd5,
    KEY_DIV    = 4'd6,
    KEY_EQUALS = 4'd7,
    KEY_CLEAR  = 4'd8
  } key_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_KEY,
    CMD_DIGIT_MUL,
    CMD_DIGIT_FIN,
    CMD_EQ_START,
    CMD_LONG_STEP,
    CMD_EQ_FIN
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  mode;
    logic [3:0]  digit;
  } ctrl_t;

  typedef struct packed {
    logic need_long;
    logic long_done;
    logic point_seen;
  } stat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] display_value;
    logic                  divide_by_zero;
    logic                  overflow;
  } res_t;
endpackage

### hdl/ffc_if.sv
// Valid/ready channel interfaces for key requests and results.
interface ffc_key_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [3:0] digit;
  modport source (output valid, mode, digit, input ready);
  modport sink (input valid, mode, digit, output ready);
endinterface

interface ffc_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] display_value;
  logic        divide_by_zero;
  logic        overflow;
  modport source (output valid, display_value, divide_by_zero, overflow, input ready);
  modport sink (input valid, display_value, divide_by_zero, overflow, output ready);
endinterface

### hdl/ffc_datapath.sv
// Datapath: calculator state, shift-add multiplier and restoring divider.
module ffc_datapath
  import ffc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  output stat_t stat_o,
  output res_t  res_o
);
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned WB = WIDE_BITS;
  localparam logic [VB-1:0] POS_LIM = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] ONE_FX = VB'(1) << FRAC_BITS;
  localparam logic [VB-1:0] TENTH = VB'((ONE_FX + VB'(5)) / VB'(10));

  logic signed [VB-1:0] entry_q, acc_q;
  logic                 point_q, opv_q;
  logic [VB-1:0]        place_q;
  op_e                  op_q;
  // Long-operation registers.
  logic [WB-1:0]        num_q;     // multiplier product or dividend shift
  logic [VB-1:0]        mcand_q;   // multiplicand or divisor
  logic [VB-1:0]        mplier_q;  // multiplier bits
  logic [VB-1:0]        rem_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic                 neg_q;
  logic                 ovf_q, dz_q;

  // Saturate a sign-magnitude wide value to the value range.
  function automatic logic [VB:0] sat(input logic neg, input logic [WB-1:0] m);
    logic [VB-1:0] lim;
    logic [VB-1:0] v;
    logic          o;
    lim = neg ? POS_LIM + VB'(1) : POS_LIM;
    o = (m[WB-1:VB] != '0) || (m[VB-1:0] > lim);
    v = o ? lim : m[VB-1:0];
    v = neg ? (~v + VB'(1)) : v;
    return {o, v};
  endfunction

  function automatic logic [VB-1:0] mag(input logic [VB-1:0] v);
    return v[VB-1] ? (~v + VB'(1)) : v;
  endfunction

  // Signed add in sign-magnitude form, result saturated.
  function automatic logic [VB:0] smadd(input logic an, input logic [WB-1:0] am,
                                         input logic bn, input logic [WB-1:0] bm);
    logic [WB-1:0] r;
    logic          n;
    if (an == bn) begin
      r = am + bm;
      n = an;
    end else if (am >= bm) begin
      r = am - bm;
      n = an;
    end else begin
      r = bm - am;
      n = bn;
    end
    return sat(n, r);
  endfunction

  logic [VB:0]   sum_s;
  logic [VB-1:0] dig9;
  logic [VB:0]   tri_rem;
  logic [VB-1:0] mag_e, mag_a;
  logic [VB-1:0] frac_add;
  logic [31:0]   place5;
  logic [63:0]   place_rcp;

  assign mag_e = mag(entry_q);
  assign mag_a = mag(acc_q);
  assign dig9 = (ctrl_i.digit > 4'd9) ? VB'(9) : VB'(ctrl_i.digit);
  assign tri_rem = {rem_q, num_q[WB-1]};

  // Fraction digit weight: digit times place value by shift and add.
  assign frac_add = (dig9[0] ? place_q : '0) + (dig9[1] ? (place_q << 1) : '0) +
                    (dig9[2] ? (place_q << 2) : '0) + (dig9[3] ? (place_q << 3) : '0);

  // Next place value, rounded divide by ten through a reciprocal multiply.
  // The place value never exceeds one tenth, so it fits in 32 bits.
  assign place5 = place_q[31:0] + 32'd5;
  assign place_rcp = 64'(place5) * 64'(32'hCCCC_CCCD);

  assign stat_o.need_long = opv_q && (op_q == OP_MUL || op_q == OP_DIV) &&
                            !(op_q == OP_DIV && mag_e == '0);
  assign stat_o.long_done = (cnt_q == '0);
  assign stat_o.point_seen = point_q;
  assign res_o.display_value = entry_q;
  assign res_o.divide_by_zero = dz_q;
  assign res_o.overflow = ovf_q;

  always_comb begin
    sum_s = '0;
    if (op_q == OP_MUL) begin
      sum_s = sat(neg_q, num_q >> FRAC_BITS);
    end else begin
      sum_s = sat(neg_q, num_q);
    end
  end

  // State updates per command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [VB:0] t;
    if (!rst_ni) begin
      entry_q <= '0; acc_q <= '0; point_q <= 1'b0; place_q <= '0;
      op_q <= OP_ADD; opv_q <= 1'b0; ovf_q <= 1'b0; dz_q <= 1'b0;
      cnt_q <= '0; neg_q <= 1'b0; num_q <= '0; mcand_q <= '0;
      mplier_q <= '0; rem_q <= '0;
    end else begin
      case (ctrl_i.cmd)
        CMD_KEY: begin
          ovf_q <= 1'b0;
          dz_q <= 1'b0;
          case (ctrl_i.mode)
            KEY_DIGIT: begin
              if (point_q) begin
                t = smadd(entry_q[VB-1], WB'(mag_e), 1'b0, WB'(frac_add));
                entry_q <= t[VB-1:0];
                ovf_q <= t[VB];
                place_q <= VB'(place_rcp[63:35]);
              end else begin
                // Integer digit: entry * 10 first, added next cycle.
                num_q <= (WB'(mag_e) << 3) + (WB'(mag_e) << 1);
                neg_q <= entry_q[VB-1];
              end
            end
            KEY_POINT: begin
              point_q <= 1'b1;
              place_q <= TENTH;
            end
            KEY_NEGATE: begin
              t = sat(!entry_q[VB-1], WB'(mag_e));
              entry_q <= t[VB-1:0];
              ovf_q <= t[VB];
            end
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
              acc_q <= entry_q;
              entry_q <= '0;
              point_q <= 1'b0;
              place_q <= '0;
              op_q <= op_e'(2'(ctrl_i.mode - KEY_ADD));
              opv_q <= 1'b1;
            end
            KEY_EQUALS: begin
              if (opv_q) begin
                case (op_q)
                  OP_ADD, OP_SUB: begin
                    t = smadd(acc_q[VB-1], WB'(mag_a),
                              entry_q[VB-1] ^ (op_q == OP_SUB), WB'(mag_e));
                    acc_q <= t[VB-1:0];
                    entry_q <= t[VB-1:0];
                    ovf_q <= t[VB];
                  end
                  default: begin
                    if (op_q == OP_DIV && mag_e == '0) begin
                      entry_q <= '0;
                      dz_q <= 1'b1;
                    end
                  end
                endcase
              end
            end
            KEY_CLEAR: begin
              entry_q <= '0; acc_q <= '0; point_q <= 1'b0; place_q <= '0;
            end
            default: ;
          endcase
        end
        CMD_DIGIT_FIN: begin
          t = smadd(neg_q, num_q, 1'b0, WB'(dig9) << FRAC_BITS);
          entry_q <= t[VB-1:0];
          ovf_q <= t[VB];
        end
        CMD_EQ_START: begin
          neg_q <= acc_q[VB-1] ^ entry_q[VB-1];
          rem_q <= '0;
          if (op_q == OP_MUL) begin
            num_q <= '0;
            mcand_q <= mag_a;
            mplier_q <= mag_e;
            cnt_q <= CNT_BITS'(VB);
          end else begin
            num_q <= WB'(mag_a) << FRAC_BITS;
            mcand_q <= mag_e;
            cnt_q <= CNT_BITS'(WB);
          end
        end
        CMD_LONG_STEP: begin
          cnt_q <= cnt_q - CNT_BITS'(1);
          if (op_q == OP_MUL) begin
            // Shift-add, multiplier bits from the top.
            num_q <= (num_q << 1) + (mplier_q[VB-1] ? WB'(mcand_q) : WB'(0));
            mplier_q <= mplier_q << 1;
          end else begin
            // Restoring divide: quotient shifts into num_q.
            if (rem_q[VB-1] || (tri_rem >= {1'b0, mcand_q})) begin
              rem_q <= VB'(tri_rem - {1'b0, mcand_q});
              num_q <= {num_q[WB-2:0], 1'b1};
            end else begin
              rem_q <= tri_rem[VB-1:0];
              num_q <= {num_q[WB-2:0], 1'b0};
            end
          end
        end
        CMD_EQ_FIN: begin
          acc_q <= sum_s[VB-1:0];
          entry_q <= sum_s[VB-1:0];
          ovf_q <= sum_s[VB];
        end
        default: ;
      endcase
    end
  end
endmodule

### hdl/ffc_ctrl.sv
// Controller: sequences each key request and drives the result channel from the datapath.
module ffc_ctrl
  import ffc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  ffc_key_if.sink   key,
  ffc_res_if.source res,
  input  stat_t stat_i,
  input  res_t  dp_i,
  output ctrl_t ctrl_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIGIT, S_EQ, S_LONG, S_FIN, S_LOAD, S_OUT
  } state_e;

  state_e state_q;
  logic [3:0] mode_q, digit_q;
  logic       is_int_digit;

  assign key.ready = (state_q == S_IDLE);
  assign res.valid = (state_q == S_OUT);
  assign ctrl_o.mode = mode_q;
  assign ctrl_o.digit = digit_q;
  assign res.display_value = dp_i.display_value;
  assign res.divide_by_zero = dp_i.divide_by_zero;
  assign res.overflow = dp_i.overflow;
  assign is_int_digit = (mode_q == KEY_DIGIT) && !stat_i.point_seen;

  // Command decode from state; the long unit stops once its count is spent.
  always_comb begin
    case (state_q)
      S_LOAD:  ctrl_o.cmd = CMD_KEY;
      S_DIGIT: ctrl_o.cmd = CMD_DIGIT_FIN;
      S_EQ:    ctrl_o.cmd = CMD_EQ_START;
      S_LONG:  ctrl_o.cmd = stat_i.long_done ? CMD_NONE : CMD_LONG_STEP;
      S_FIN:   ctrl_o.cmd = CMD_EQ_FIN;
      default: ctrl_o.cmd = CMD_NONE;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= '0;
      digit_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (key.valid) begin
            mode_q <= key.mode;
            digit_q <= key.digit;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          // The digit path needs the datapath's point state, checked below.
          if (is_int_digit) state_q <= S_DIGIT;
          else if (mode_q == KEY_EQUALS && stat_i.need_long) state_q <= S_EQ;
          else state_q <= S_OUT;
        end
        S_DIGIT: state_q <= S_OUT;
        S_EQ:    state_q <= S_LONG;
        S_LONG:  if (stat_i.long_done) state_q <= S_FIN;
        S_FIN:   state_q <= S_OUT;
        S_OUT:   if (res.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/four_function_calculator_keypad_top.sv
// A key request passes through the load state, then the result state; an integer
// digit adds a digit state, and equals with a multiply or nonzero divide adds the
// start, long-step and finish states. One key at a time; the next request is taken
// in the cycle after the result is taken. The divide length is set by the 128-step
// restoring divider, multiply by the 64-step shift-add unit.
// Asynchronous active-low reset clears all state.
module four_function_calculator_keypad_top
  import ffc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  ffc_key_if.sink   key_i,
  ffc_res_if.source res_o
);
  ctrl_t ctrl;
  stat_t stat;
  res_t  dres;

  ffc_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .key(key_i), .res(res_o),
    .stat_i(stat), .dp_i(dres), .ctrl_o(ctrl)
  );

  ffc_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .stat_o(stat), .res_o(dres)
  );
endmodule

### hdl/ffc_checker.sv
// Port-level checker for the calculator, bound to the top level.
`include "assert_macros.svh"
module ffc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic key_valid,
  input logic key_ready,
  input logic res_valid,
  input logic res_ready,
  input logic dz,
  input logic [63:0] val
);
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, res_valid, !key_ready, "ready while result pending")
  `ASSERT_NEXT(a_start, clk_i, rst_ni, key_valid && key_ready, !res_valid, "result too early")
  `ASSERT_IMPL(a_dz, clk_i, rst_ni, res_valid && dz, val == 64'd0, "div zero nonzero value")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, res_valid && !res_ready, res_valid && $stable(val),
               "result dropped")
endmodule

bind four_function_calculator_keypad_top ffc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .key_valid(key_i.valid), .key_ready(key_i.ready),
  .res_valid(res_o.valid), .res_ready(res_o.ready), .dz(res_o.divide_by_zero),
  .val(res_o.display_value)
);
